// File: rtl/assert_macros.svh
// Assertion macros used by the checker file anlr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define AN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while reset is low.
`define AN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/anlr_pkg.sv
`timescale 1ns / 1ps

package anlr_pkg;

  // Largest frame length accepted in the size byte
  localparam logic [7:0] MAX_FRAME = 8'd128;
  localparam logic [7:0] MIN_SIZE  = 8'd3;

  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_TXDONE = 2'd2;

  localparam logic [1:0] RP_NONE = 2'd0;
  localparam logic [1:0] RP_ACK  = 2'd1;
  localparam logic [1:0] RP_NAK  = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ACKED    = 3'd1;
  localparam logic [2:0] EV_ACCEPTED = 3'd2;
  localparam logic [2:0] EV_RETRY    = 3'd3;
  localparam logic [2:0] EV_GIVEUP   = 3'd4;

  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RX_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_RETRY       = 2'd2;

  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] RX_TIMEOUT_RST   = 16'd1000;
  localparam logic [7:0]  RETRY_RELOAD_RST = 8'd25;

  typedef enum logic [2:0] {
    PH_TXWAIT = 3'b001,
    PH_REPLY  = 3'b010,
    PH_RX     = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  byte_count;
    logic [7:0]  frame_length;
    logic [7:0]  running_sum;
    logic [15:0] tick_timer;
    logic [7:0]  retry_counter;
  } link_state_t;

  typedef struct packed {
    logic [15:0] ack_timeout_ticks;
    logic [15:0] rx_timeout_ticks;
    logic [7:0]  retry_reload;
  } link_cfg_t;

  typedef struct packed {
    logic [1:0] reply;
    logic [2:0] event_res;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_position;
    logic [7:0] retries_left;
  } link_result_t;

endpackage

// File: rtl/anlr_step.sv
`timescale 1ns / 1ps

module anlr_step (
  input  anlr_pkg::link_state_t  state_i,
  input  anlr_pkg::link_cfg_t    cfg_i,
  input  logic [1:0]             mode_i,
  input  logic [7:0]             rx_byte_i,
  output anlr_pkg::link_state_t  state_o,
  output anlr_pkg::link_result_t result_o
);
  import anlr_pkg::*;

  logic [7:0]  retry_dec;
  logic [2:0]  fail_ev;
  logic        tick_exp;
  logic [15:0] tick_dec;
  logic [7:0]  sum_add;

  // Failure path: decrement, saturating at zero
  assign retry_dec = (state_i.retry_counter != 8'd0) ? state_i.retry_counter - 8'd1 : 8'd0;
  assign fail_ev   = (retry_dec != 8'd0) ? EV_RETRY : EV_GIVEUP;
  assign tick_exp  = (state_i.tick_timer <= 16'd1);
  assign tick_dec  = state_i.tick_timer - 16'd1;
  assign sum_add   = state_i.running_sum + rx_byte_i;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (mode_i)
      MODE_TXDONE: begin
        if (state_i.phase == PH_TXWAIT) begin
          state_o.phase      = PH_REPLY;
          state_o.tick_timer = cfg_i.ack_timeout_ticks;
        end
      end
      MODE_TICK: begin
        if (state_i.phase == PH_REPLY || state_i.phase == PH_RX) begin
          if (tick_exp) begin
            state_o.tick_timer    = 16'd0;
            state_o.phase         = PH_TXWAIT;
            state_o.byte_count    = 8'd0;
            state_o.retry_counter = retry_dec;
            result_o.event_res    = fail_ev;
            // no reply byte while we are the one waiting
            if (state_i.phase == PH_RX) begin
              result_o.reply = RP_NAK;
            end
          end else begin
            state_o.tick_timer = tick_dec;
          end
        end
      end
      MODE_BYTE: begin
        unique case (state_i.phase)
          PH_REPLY: begin
            if (rx_byte_i == CH_ACK) begin
              state_o.phase         = PH_TXWAIT;
              state_o.byte_count    = 8'd0;
              state_o.retry_counter = cfg_i.retry_reload;
              result_o.event_res    = EV_ACKED;
            end else if (rx_byte_i == CH_ENQ) begin
              state_o.phase        = PH_RX;
              state_o.byte_count   = 8'd1;
              state_o.frame_length = 8'd0;
              state_o.running_sum  = 8'd0;
              state_o.tick_timer   = cfg_i.rx_timeout_ticks;
            end else if (rx_byte_i == CH_NAK) begin
              state_o.phase         = PH_TXWAIT;
              state_o.byte_count    = 8'd0;
              state_o.retry_counter = retry_dec;
              result_o.event_res    = fail_ev;
            end
          end
          PH_RX: begin
            if (state_i.byte_count < MIN_SIZE) begin
              result_o.data_valid    = 1'b1;
              result_o.data_byte     = rx_byte_i;
              result_o.data_position = state_i.byte_count[6:0];
              if (state_i.byte_count == 8'd1) begin
                state_o.running_sum = rx_byte_i;
                state_o.byte_count  = 8'd2;
              end else begin
                state_o.running_sum = sum_add;
                state_o.byte_count  = 8'd3;
                if (rx_byte_i < MIN_SIZE || rx_byte_i > MAX_FRAME) begin
                  result_o.reply        = RP_NAK;
                  state_o.phase         = PH_TXWAIT;
                  state_o.byte_count    = 8'd0;
                  state_o.retry_counter = retry_dec;
                  result_o.event_res    = fail_ev;
                end else begin
                  state_o.frame_length = rx_byte_i;
                end
              end
            end else if (state_i.byte_count >= state_i.frame_length) begin
              // checksum byte: not streamed
              state_o.phase      = PH_TXWAIT;
              state_o.byte_count = 8'd0;
              if (rx_byte_i == state_i.running_sum) begin
                result_o.reply        = RP_ACK;
                state_o.retry_counter = cfg_i.retry_reload;
                result_o.event_res    = EV_ACCEPTED;
              end else begin
                result_o.reply        = RP_NAK;
                state_o.retry_counter = retry_dec;
                result_o.event_res    = fail_ev;
              end
            end else begin
              result_o.data_valid    = 1'b1;
              result_o.data_byte     = rx_byte_i;
              result_o.data_position = state_i.byte_count[6:0];
              state_o.running_sum    = sum_add;
              state_o.byte_count     = state_i.byte_count + 8'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    result_o.retries_left = state_o.retry_counter;
  end

endmodule

// File: rtl/ack_nak_link_receiver_core.sv
`timescale 1ns / 1ps

// Receive side of a stop-and-wait ACK/NAK serial link. Each input item is a
// received byte, a timer tick or an own-transmission-done strobe, and gives
// exactly one result item: the reply byte code to send, an exchange event,
// a streamed frame byte with its position, and the retry count left. Frame
// bytes are streamed as they arrive, so a frame that ends in a NAK reply
// must be discarded downstream. One item is taken every clock cycle while
// in_ready is high; its result sits in the output register from the next
// cycle; in_ready is high while that register is empty or being taken.
// Timeouts and the retry reload are set through APB registers 0x0, 0x4 and
// 0x8. The user must write them only while idle; the block does not check.
module ack_nak_link_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_reply,
  output logic [2:0]  out_event_res,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [6:0]  out_data_position,
  output logic [7:0]  out_retries_left,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import anlr_pkg::*;

  link_cfg_t    cfg_r;
  link_state_t  state_r, state_nxt;
  link_result_t out_r, out_nxt;
  logic         out_valid_r;
  logic         in_fire;
  logic         cfg_wr;
  logic [1:0]   reg_idx;

  assign pready   = 1'b1;
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_idx  = paddr[3:2];

  anlr_step u_step (
    .state_i   (state_r),
    .cfg_i     (cfg_r),
    .mode_i    (in_mode),
    .rx_byte_i (in_rx_byte),
    .state_o   (state_nxt),
    .result_o  (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_RST;
      cfg_r.rx_timeout_ticks  <= RX_TIMEOUT_RST;
      cfg_r.retry_reload      <= RETRY_RELOAD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACK_TIMEOUT: cfg_r.ack_timeout_ticks <= pwdata[15:0];
        REG_RX_TIMEOUT:  cfg_r.rx_timeout_ticks  <= pwdata[15:0];
        REG_RETRY:       cfg_r.retry_reload      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACK_TIMEOUT: prdata = {16'd0, cfg_r.ack_timeout_ticks};
      REG_RX_TIMEOUT:  prdata = {16'd0, cfg_r.rx_timeout_ticks};
      REG_RETRY:       prdata = {24'd0, cfg_r.retry_reload};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_TXWAIT;
      state_r.byte_count    <= 8'd0;
      state_r.frame_length  <= 8'd0;
      state_r.running_sum   <= 8'd0;
      state_r.tick_timer    <= 16'd0;
      state_r.retry_counter <= 8'd0;
      out_valid_r           <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load with each accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply         = out_r.reply;
  assign out_event_res     = out_r.event_res;
  assign out_data_valid    = out_r.data_valid;
  assign out_data_byte     = out_r.data_byte;
  assign out_data_position = out_r.data_position;
  assign out_retries_left  = out_r.retries_left;

endmodule

// File: rtl/anlr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module anlr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_reply,
  input logic [2:0] out_event_res,
  input logic       out_data_valid,
  input logic [7:0] out_data_byte,
  input logic [6:0] out_data_position,
  input logic [7:0] out_retries_left
);
  import anlr_pkg::*;

  logic [28:0] out_payload;
  logic        out_stalled;
  logic        ack_reply;
  logic        giveup_ev;
  logic        stream_byte;
  logic        idle_byte;
  logic        stream_clear;

  assign out_payload  = {out_reply, out_event_res, out_data_valid, out_data_byte,
                         out_data_position, out_retries_left};
  assign out_stalled  = out_valid && !out_ready;
  assign ack_reply    = out_valid && (out_reply == RP_ACK);
  assign giveup_ev    = out_valid && (out_event_res == EV_GIVEUP);
  assign stream_byte  = out_valid && out_data_valid;
  assign idle_byte    = out_valid && !out_data_valid;
  assign stream_clear = (out_data_byte == 8'd0) && (out_data_position == 7'd0);

  // A held result keeps its payload
  `AN_ASSERT_NXT(a_out_hold, clk, rst_n, out_stalled, out_valid && $stable(out_payload))
  // An ACK reply only answers an accepted frame
  `AN_ASSERT_IMP(a_ack_accepted, clk, rst_n, ack_reply, out_event_res == EV_ACCEPTED)
  // Give up only with the counter run down
  `AN_ASSERT_IMP(a_giveup_zero, clk, rst_n, giveup_ev, out_retries_left == 8'd0)
  // A streamed byte never sits at the ENQ position
  `AN_ASSERT_IMP(a_pos_nonzero, clk, rst_n, stream_byte, out_data_position != 7'd0)
  // No stream byte: byte and position are cleared
  `AN_ASSERT_IMP(a_idle_clear, clk, rst_n, idle_byte, stream_clear)

endmodule

bind ack_nak_link_receiver_core anlr_checker u_anlr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_reply         (out_reply),
  .out_event_res     (out_event_res),
  .out_data_valid    (out_data_valid),
  .out_data_byte     (out_data_byte),
  .out_data_position (out_data_position),
  .out_retries_left  (out_retries_left)
);
